// ===== src/elevator_car_controller_macros.svh =====
// Assertion macros shared by the checker modules of the elevator car controller.
// No dependencies; include by bare file name.
`ifndef ELEVATOR_CAR_CONTROLLER_MACROS_SVH
`define ELEVATOR_CAR_CONTROLLER_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ECC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset names.
`define ECC_ASSERT(label, prop, msg) \
  `ECC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/ecc_pkg.sv =====
// Package of the elevator car controller: codes, register defaults, config struct.
// No dependencies; used by every module of the block.
package ecc_pkg;

  typedef enum logic [2:0] {
    ACT_IDLE    = 3'd0,
    ACT_OPENING = 3'd1,
    ACT_OPENED  = 3'd2,
    ACT_CLOSING = 3'd3,
    ACT_CLOSED  = 3'd4,
    ACT_ACCEL   = 3'd5,
    ACT_MOVING  = 3'd6,
    ACT_SLOWING = 3'd7
  } activity_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    MODE_TIMER       = 2'd0,
    MODE_IDLE_CHECK  = 2'd1,
    MODE_CALL        = 2'd2,
    MODE_ARRIVAL     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CALL_HALL_UP   = 2'd0,
    CALL_HALL_DOWN = 2'd1,
    CALL_CAR       = 2'd2
  } call_kind_e;

  typedef enum logic [2:0] {
    REG_DOOR_TEST   = 3'd0,
    REG_DOOR_MOVE   = 3'd1,
    REG_ACCELERATE  = 3'd2,
    REG_UP_FLOOR    = 3'd3,
    REG_DOWN_FLOOR  = 3'd4,
    REG_UP_BRAKE    = 3'd5,
    REG_DOWN_BRAKE  = 3'd6,
    REG_IDLE_WAIT   = 3'd7
  } cfg_index_e;

  localparam int CfgIndexW = 3;
  localparam int TicksW    = 16;
  localparam int HomeFloor = 1;

  // Passengers at or above this count leave no room for waiters to board.
  localparam logic [3:0] CarCapacity = 4'd12;

  localparam logic [TicksW-1:0] RstDoorTest  = 16'd40;
  localparam logic [TicksW-1:0] RstDoorMove  = 16'd20;
  localparam logic [TicksW-1:0] RstAccel     = 16'd15;
  localparam logic [TicksW-1:0] RstUpFloor   = 16'd51;
  localparam logic [TicksW-1:0] RstDownFloor = 16'd61;
  localparam logic [TicksW-1:0] RstUpBrake   = 16'd14;
  localparam logic [TicksW-1:0] RstDownBrake = 16'd23;
  localparam logic [TicksW-1:0] RstIdleWait  = 16'd300;

  typedef struct packed {
    logic [TicksW-1:0] door_test_period;
    logic [TicksW-1:0] door_move_time;
    logic [TicksW-1:0] accelerate_period;
    logic [TicksW-1:0] up_floor_time;
    logic [TicksW-1:0] down_floor_time;
    logic [TicksW-1:0] up_brake_time;
    logic [TicksW-1:0] down_brake_time;
    logic [TicksW-1:0] idle_wait_time;
  } cfg_regs_t;

endpackage

// ===== src/elevator_car_controller.sv =====
// Single-car elevator controller: one event per transaction, one result per event.
// An accepted event is held in the input register; one pass of next-state logic in
// ecc_core updates the car state and the result lands in the output register in the
// same cycle. A new event can enter every clock unless results stall. The input side
// stays ready while a result waits, until both registers are full. Timing registers are
// written one per cycle on the cfg channel; the user must write them only while no event
// is in flight, which the block does not enforce. Depends on ecc_pkg, ecc_cfg_regs and ecc_core.
module elevator_car_controller #(
  parameter int TOP_FLOOR = 4,
  localparam int FloorW = $clog2(TOP_FLOOR + 1),
  localparam int InDataW = ((FloorW + 8 + 7) / 8) * 8,
  localparam int OutDataW = ((FloorW + 21 + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // call_floor, riders_to_exit, up_waiters, down_waiters, load_count, transfer_busy
  input  logic [InDataW-1:0]                 s_axis_tdata,
  // mode, call_kind
  input  logic [3:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // activity, direction, car_floor, reload_ticks
  output logic [OutDataW-1:0]                m_axis_tdata,
  // reload_valid
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ecc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [ecc_pkg::TicksW-1:0]         cfg_data_i
);

  ecc_pkg::cfg_regs_t cfg;

  logic                 in_valid_q, in_valid_d;
  ecc_pkg::mode_e       in_mode_q;
  logic [1:0]           in_kind_q;
  logic [FloorW-1:0]    in_floor_q;
  logic                 in_riders_q, in_upw_q, in_dnw_q, in_busy_q;
  logic [3:0]           in_load_q;

  logic                 out_valid_q, out_valid_d;
  ecc_pkg::activity_e   out_act_q;
  ecc_pkg::dir_e        out_dir_q;
  logic [FloorW-1:0]    out_floor_q;
  logic [ecc_pkg::TicksW-1:0] out_ticks_q;
  logic                 out_reload_q;

  ecc_pkg::activity_e   nxt_act;
  ecc_pkg::dir_e        nxt_dir;
  logic [FloorW-1:0]    nxt_floor;
  logic [ecc_pkg::TicksW-1:0] nxt_ticks;
  logic                 nxt_reload;

  logic in_fire, advance;

  // An event is processed when the output register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_mode_q   <= ecc_pkg::mode_e'(s_axis_tuser[1:0]);
      in_kind_q   <= s_axis_tuser[3:2];
      in_floor_q  <= s_axis_tdata[FloorW-1:0];
      in_riders_q <= s_axis_tdata[FloorW];
      in_upw_q    <= s_axis_tdata[FloorW+1];
      in_dnw_q    <= s_axis_tdata[FloorW+2];
      in_load_q   <= s_axis_tdata[FloorW+6:FloorW+3];
      in_busy_q   <= s_axis_tdata[FloorW+7];
    end
    if (advance) begin
      out_act_q    <= nxt_act;
      out_dir_q    <= nxt_dir;
      out_floor_q  <= nxt_floor;
      out_ticks_q  <= nxt_ticks;
      out_reload_q <= nxt_reload;
    end
  end

  ecc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ecc_core #(
    .TOP_FLOOR (TOP_FLOOR)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_valid_i      (advance),
    .mode_i           (in_mode_q),
    .call_kind_i      (in_kind_q),
    .call_floor_i     (in_floor_q),
    .riders_to_exit_i (in_riders_q),
    .up_waiters_i     (in_upw_q),
    .down_waiters_i   (in_dnw_q),
    .load_count_i     (in_load_q),
    .transfer_busy_i  (in_busy_q),
    .cfg_i            (cfg),
    .activity_o       (nxt_act),
    .direction_o      (nxt_dir),
    .car_floor_o      (nxt_floor),
    .reload_ticks_o   (nxt_ticks),
    .reload_valid_o   (nxt_reload)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_ticks_q, out_floor_q, out_dir_q, out_act_q});
  assign m_axis_tuser  = out_reload_q;

endmodule

// ===== src/ecc_cfg_regs.sv =====
// Timing configuration registers of the elevator car controller.
// Depends on ecc_pkg for the register indexes, defaults and cfg_regs_t.
module ecc_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [ecc_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [ecc_pkg::TicksW-1:0]            cfg_data_i,
  output ecc_pkg::cfg_regs_t                    cfg_o
);

  ecc_pkg::cfg_regs_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ecc_pkg::cfg_index_e'(cfg_index_i))
        ecc_pkg::REG_DOOR_TEST:  cfg_d.door_test_period  = cfg_data_i;
        ecc_pkg::REG_DOOR_MOVE:  cfg_d.door_move_time    = cfg_data_i;
        ecc_pkg::REG_ACCELERATE: cfg_d.accelerate_period = cfg_data_i;
        ecc_pkg::REG_UP_FLOOR:   cfg_d.up_floor_time     = cfg_data_i;
        ecc_pkg::REG_DOWN_FLOOR: cfg_d.down_floor_time   = cfg_data_i;
        ecc_pkg::REG_UP_BRAKE:   cfg_d.up_brake_time     = cfg_data_i;
        ecc_pkg::REG_DOWN_BRAKE: cfg_d.down_brake_time   = cfg_data_i;
        ecc_pkg::REG_IDLE_WAIT:  cfg_d.idle_wait_time    = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.door_test_period  <= ecc_pkg::RstDoorTest;
      cfg_q.door_move_time    <= ecc_pkg::RstDoorMove;
      cfg_q.accelerate_period <= ecc_pkg::RstAccel;
      cfg_q.up_floor_time     <= ecc_pkg::RstUpFloor;
      cfg_q.down_floor_time   <= ecc_pkg::RstDownFloor;
      cfg_q.up_brake_time     <= ecc_pkg::RstUpBrake;
      cfg_q.down_brake_time   <= ecc_pkg::RstDownBrake;
      cfg_q.idle_wait_time    <= ecc_pkg::RstIdleWait;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ecc_core.sv =====
// Car state registers and the single-pass next-state logic for one event.
// Depends on ecc_pkg for activity, direction, event and call codes.
module ecc_core #(
  parameter int TOP_FLOOR = 4,
  localparam int NumFloors = TOP_FLOOR + 1,
  localparam int FloorW = $clog2(NumFloors)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          evt_valid_i,
  input  ecc_pkg::mode_e                mode_i,
  input  logic [1:0]                    call_kind_i,
  input  logic [FloorW-1:0]             call_floor_i,
  input  logic                          riders_to_exit_i,
  input  logic                          up_waiters_i,
  input  logic                          down_waiters_i,
  input  logic [3:0]                    load_count_i,
  input  logic                          transfer_busy_i,
  input  ecc_pkg::cfg_regs_t            cfg_i,
  output ecc_pkg::activity_e            activity_o,
  output ecc_pkg::dir_e                 direction_o,
  output logic [FloorW-1:0]             car_floor_o,
  output logic [ecc_pkg::TicksW-1:0]    reload_ticks_o,
  output logic                          reload_valid_o
);

  localparam logic [FloorW-1:0] TopF  = FloorW'(TOP_FLOOR);
  localparam logic [FloorW-1:0] HomeF = FloorW'(ecc_pkg::HomeFloor);

  ecc_pkg::activity_e     act_q, act_d;
  ecc_pkg::dir_e          dir_q, dir_d;
  logic [FloorW-1:0]      floor_q, floor_d;
  logic                   rev_q, rev_d;
  logic                   entry_q, entry_d;
  logic [NumFloors-1:0]   car_q, car_d;
  logic [NumFloors-1:0]   hup_q, hup_d;
  logic [NumFloors-1:0]   hdn_q, hdn_d;

  function automatic logic [NumFloors-1:0] above_of(input logic [FloorW-1:0] f);
    logic [NumFloors-1:0] r;
    for (int i = 0; i < NumFloors; i++) r[i] = (FloorW'(i) > f);
    return r;
  endfunction

  function automatic logic [NumFloors-1:0] below_of(input logic [FloorW-1:0] f);
    logic [NumFloors-1:0] r;
    for (int i = 0; i < NumFloors; i++) r[i] = (FloorW'(i) < f);
    return r;
  endfunction

  function automatic logic [FloorW-1:0] lowest_set(input logic [NumFloors-1:0] v);
    logic [FloorW-1:0] idx;
    idx = '0;
    for (int i = NumFloors - 1; i >= 0; i--) if (v[i]) idx = FloorW'(i);
    return idx;
  endfunction

  function automatic logic [FloorW-1:0] highest_set(input logic [NumFloors-1:0] v);
    logic [FloorW-1:0] idx;
    idx = '0;
    for (int i = 0; i < NumFloors; i++) if (v[i]) idx = FloorW'(i);
    return idx;
  endfunction

  logic [NumFloors-1:0] fbit, home_bit, all_calls, hall_calls, car_clr;
  logic [NumFloors-1:0] hall_above, hall_below;
  logic [FloorW-1:0]    f_up, f_dn, up_idx, dn_idx, up_dist, dn_dist;
  logic                 room, xfer_pending, clear_up, clear_dn, stop_up, stop_dn;
  logic                 go_up, go_dn, pick_up;
  logic [ecc_pkg::TicksW-1:0] ticks;
  logic                 valid;

  always_comb begin
    fbit       = NumFloors'(1) << floor_q;
    home_bit   = NumFloors'(1) << ecc_pkg::HomeFloor;
    all_calls  = hup_q | hdn_q | car_q;
    hall_calls = hup_q | hdn_q;
    car_clr    = car_q & ~fbit;

    room = load_count_i < ecc_pkg::CarCapacity;
    xfer_pending = riders_to_exit_i || transfer_busy_i ||
                   (up_waiters_i && room && dir_q == ecc_pkg::DIR_UP) ||
                   (down_waiters_i && room && dir_q == ecc_pkg::DIR_DOWN);

    // Floor after one step of travel; the car holds at either end.
    f_up = (floor_q < TopF) ? floor_q + FloorW'(1) : floor_q;
    f_dn = (floor_q != '0) ? floor_q - FloorW'(1) : floor_q;

    clear_up = ~|(all_calls & above_of(f_up));
    clear_dn = ~|(all_calls & below_of(f_dn));
    stop_up  = hup_q[f_up] || car_q[f_up] || ((f_up == HomeF || hdn_q[f_up]) && clear_up);
    stop_dn  = hdn_q[f_dn] || car_q[f_dn] || ((f_dn == HomeF || hup_q[f_dn]) && clear_dn);

    go_up = |(car_clr & above_of(floor_q));
    go_dn = |(car_clr & below_of(floor_q));

    // Nearest hall calls on either side; equal distances favor going up.
    hall_above = hall_calls & above_of(floor_q);
    hall_below = hall_calls & below_of(floor_q);
    up_idx  = lowest_set(hall_above);
    dn_idx  = highest_set(hall_below);
    up_dist = up_idx - floor_q;
    dn_dist = floor_q - dn_idx;
    pick_up = (|hall_above) && (~|hall_below || up_dist <= dn_dist);

    act_d   = act_q;
    dir_d   = dir_q;
    floor_d = floor_q;
    rev_d   = rev_q;
    entry_d = entry_q;
    car_d   = car_q;
    hup_d   = hup_q;
    hdn_d   = hdn_q;
    ticks   = '0;
    valid   = 1'b0;

    case (mode_i)
      ecc_pkg::MODE_TIMER: begin
        valid = 1'b1;
        case (act_q)
          ecc_pkg::ACT_IDLE: begin
            if (floor_q == HomeF) begin
              ticks = cfg_i.idle_wait_time;
            end else begin
              dir_d = (floor_q > HomeF) ? ecc_pkg::DIR_DOWN : ecc_pkg::DIR_UP;
              car_d = car_q | home_bit;
              act_d = ecc_pkg::ACT_ACCEL;
              ticks = cfg_i.accelerate_period;
            end
          end
          ecc_pkg::ACT_OPENING: begin
            entry_d = 1'b1;
            act_d   = ecc_pkg::ACT_OPENED;
            ticks   = cfg_i.door_test_period;
          end
          ecc_pkg::ACT_OPENED: begin
            if (!xfer_pending) begin
              entry_d = 1'b0;
              act_d   = ecc_pkg::ACT_CLOSING;
              ticks   = cfg_i.door_move_time;
            end else begin
              ticks = cfg_i.door_test_period;
            end
          end
          ecc_pkg::ACT_CLOSING: begin
            if (!entry_q) begin
              act_d = ecc_pkg::ACT_CLOSED;
              valid = 1'b0;
            end else begin
              act_d = ecc_pkg::ACT_OPENING;
              ticks = cfg_i.door_move_time;
            end
          end
          ecc_pkg::ACT_CLOSED: begin
            car_d = car_clr;
            if (xfer_pending) begin
              act_d = ecc_pkg::ACT_OPENING;
              ticks = cfg_i.door_move_time;
            end else if (dir_q == ecc_pkg::DIR_UP || dir_q == ecc_pkg::DIR_DOWN) begin
              if (dir_q == ecc_pkg::DIR_UP) begin
                hup_d = up_waiters_i ? (hup_q | fbit) : (hup_q & ~fbit);
              end else begin
                hdn_d = down_waiters_i ? (hdn_q | fbit) : (hdn_q & ~fbit);
              end
              if ((dir_q == ecc_pkg::DIR_UP) ? go_up : go_dn) begin
                act_d = ecc_pkg::ACT_ACCEL;
                ticks = cfg_i.accelerate_period;
              end else begin
                act_d = ecc_pkg::ACT_IDLE;
                dir_d = ecc_pkg::DIR_IDLE;
                ticks = cfg_i.idle_wait_time;
              end
            end else begin
              valid = 1'b0;
            end
          end
          ecc_pkg::ACT_ACCEL: begin
            act_d = ecc_pkg::ACT_MOVING;
            ticks = (dir_q == ecc_pkg::DIR_UP) ? cfg_i.up_floor_time : cfg_i.down_floor_time;
          end
          ecc_pkg::ACT_MOVING: begin
            if (dir_q == ecc_pkg::DIR_UP) begin
              floor_d = f_up;
              if (f_up >= TopF) begin
                rev_d = 1'b1;
                act_d = ecc_pkg::ACT_SLOWING;
                ticks = cfg_i.up_brake_time;
              end else if (stop_up) begin
                if (hdn_q[f_up] && clear_up) rev_d = 1'b1;
                act_d = ecc_pkg::ACT_SLOWING;
                ticks = cfg_i.up_brake_time;
              end else begin
                ticks = cfg_i.up_floor_time;
              end
            end else if (dir_q == ecc_pkg::DIR_DOWN) begin
              floor_d = f_dn;
              if (f_dn == '0) begin
                rev_d = 1'b1;
                act_d = ecc_pkg::ACT_SLOWING;
                ticks = cfg_i.down_brake_time;
              end else if (stop_dn) begin
                if (hup_q[f_dn] && clear_dn) rev_d = 1'b1;
                act_d = ecc_pkg::ACT_SLOWING;
                ticks = cfg_i.down_brake_time;
              end else begin
                ticks = cfg_i.down_floor_time;
              end
            end else begin
              valid = 1'b0;
            end
          end
          default: begin
            // Slowing always ends with the door opening at the current floor.
            car_d = car_clr;
            act_d = ecc_pkg::ACT_OPENING;
            ticks = cfg_i.door_move_time;
            if (dir_q == ecc_pkg::DIR_UP) begin
              if (rev_q) dir_d = ecc_pkg::DIR_DOWN;
              rev_d = 1'b0;
            end else if (dir_q == ecc_pkg::DIR_DOWN) begin
              if (rev_q) dir_d = ecc_pkg::DIR_UP;
              rev_d = 1'b0;
            end
          end
        endcase
      end
      ecc_pkg::MODE_IDLE_CHECK: begin
        if (act_q == ecc_pkg::ACT_IDLE) begin
          if (hup_q[floor_q]) begin
            hup_d = hup_q & ~fbit;
            act_d = ecc_pkg::ACT_OPENING;
            dir_d = ecc_pkg::DIR_UP;
            ticks = cfg_i.door_move_time;
            valid = 1'b1;
          end else if (hdn_q[floor_q]) begin
            hdn_d = hdn_q & ~fbit;
            act_d = ecc_pkg::ACT_OPENING;
            dir_d = ecc_pkg::DIR_DOWN;
            ticks = cfg_i.door_move_time;
            valid = 1'b1;
          end else if (|hall_above || |hall_below) begin
            dir_d = pick_up ? ecc_pkg::DIR_UP : ecc_pkg::DIR_DOWN;
            act_d = ecc_pkg::ACT_ACCEL;
            ticks = cfg_i.accelerate_period;
            valid = 1'b1;
          end
        end
      end
      ecc_pkg::MODE_CALL: begin
        if (call_floor_i <= TopF) begin
          case (ecc_pkg::call_kind_e'(call_kind_i))
            ecc_pkg::CALL_HALL_UP:   hup_d = hup_q | (NumFloors'(1) << call_floor_i);
            ecc_pkg::CALL_HALL_DOWN: hdn_d = hdn_q | (NumFloors'(1) << call_floor_i);
            ecc_pkg::CALL_CAR:       car_d = car_q | (NumFloors'(1) << call_floor_i);
            default:                 car_d = car_q;
          endcase
        end
      end
      default: begin
        if (act_q == ecc_pkg::ACT_CLOSING) entry_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ecc_pkg::ACT_IDLE;
      dir_q   <= ecc_pkg::DIR_IDLE;
      floor_q <= HomeF;
      rev_q   <= 1'b0;
      entry_q <= 1'b0;
      car_q   <= '0;
      hup_q   <= '0;
      hdn_q   <= '0;
    end else if (evt_valid_i) begin
      act_q   <= act_d;
      dir_q   <= dir_d;
      floor_q <= floor_d;
      rev_q   <= rev_d;
      entry_q <= entry_d;
      car_q   <= car_d;
      hup_q   <= hup_d;
      hdn_q   <= hdn_d;
    end
  end

  assign activity_o     = act_d;
  assign direction_o    = dir_d;
  assign car_floor_o    = floor_d;
  assign reload_ticks_o = ticks;
  assign reload_valid_o = valid;

endmodule

// ===== src/ecc_checker.sv =====
// Port-level checker for the elevator car controller, bound to the top level.
// Depends on ecc_pkg and elevator_car_controller_macros.svh.
`include "elevator_car_controller_macros.svh"

module ecc_checker #(
  parameter int TOP_FLOOR = 4,
  localparam int FloorW = $clog2(TOP_FLOOR + 1),
  localparam int OutDataW = ((FloorW + 21 + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [0:0]          m_axis_tuser
);

  // An event that requests no reload reports a zero reload value.
  `ECC_ASSERT(a_no_reload_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[FloorW+20:FloorW+5] == '0), "reload ticks nonzero without reload request")

  // The car only rests idle with no travel direction.
  `ECC_ASSERT(a_idle_no_dir, (m_axis_tvalid && m_axis_tdata[2:0] == ecc_pkg::ACT_IDLE) |-> (m_axis_tdata[4:3] == ecc_pkg::DIR_IDLE), "idle activity with a travel direction")

  // With no result waiting the input side never stalls.
  `ECC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output register")

  // A stalled result holds until it is taken.
  `ECC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind elevator_car_controller ecc_checker #(
  .TOP_FLOOR (TOP_FLOOR)
) u_ecc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/elevator_car_controller_checker.sv =====
// Checker for the elevator car controller: tracks the car state from accepted events,
// predicts one status per event and compares it with each accepted result transaction.
// Depends on ecc_pkg for the activity, direction, mode, call and register codes.
module elevator_car_controller_checker
  import ecc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ev_valid_i,
  input  logic                 ev_ready_i,
  input  logic [15:0]          ev_data_i,
  input  logic [3:0]           ev_user_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [23:0]          res_data_i,
  input  logic [0:0]           res_user_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [TicksW-1:0]    cfg_data_i,
  output int                   error_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TopFloor = 4;

  typedef struct packed {
    activity_e         act;
    dir_e              dir;
    logic [2:0]        floor;
    logic [TicksW-1:0] ticks;
    logic              reload;
  } car_status_t;

  activity_e   car_act;
  dir_e        car_dir;
  logic [2:0]  car_floor;
  logic        rev_pending;
  logic        entry_flag;
  logic [4:0]  car_calls;
  logic [4:0]  hall_up;
  logic [4:0]  hall_down;
  cfg_regs_t   timing;
  car_status_t status_q[$];
  int          errors;

  function automatic logic any_call(logic [4:0] mask, int lo, int hi);
    for (int i = lo; i <= hi && i <= TopFloor; i++)
      if (mask[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Sense bits from the lowest up: riders leaving, up queue, down queue, load (4), busy.
  function automatic logic transfer_needed(logic [7:0] sense);
    logic room;
    room = sense[6:3] < CarCapacity;
    return sense[0] || sense[7] || (sense[1] && room && car_dir == DIR_UP) ||
           (sense[2] && room && car_dir == DIR_DOWN);
  endfunction

  function automatic car_status_t advance_car(logic [3:0] user, logic [15:0] data);
    car_status_t res;
    mode_e       mode;
    logic [1:0]  kind;
    logic [2:0]  cf;
    logic [7:0]  sense;
    logic [4:0]  all_calls;
    logic [4:0]  hall;
    int          f;
    int          up_d;
    int          dn_d;
    logic        clear;
    logic        go;
    logic        up_found;
    logic        dn_found;
    res = '0;
    mode = mode_e'(user[1:0]);
    kind = user[3:2];
    cf = data[2:0];
    sense = data[10:3];
    f = car_floor;
    all_calls = hall_up | hall_down | car_calls;
    hall = hall_up | hall_down;
    up_found = 1'b0;
    dn_found = 1'b0;
    up_d = 0;
    dn_d = 0;
    go = 1'b0;
    case (mode)
      MODE_TIMER: begin
        res.reload = 1'b1;
        case (car_act)
          ACT_IDLE: begin
            if (f == HomeFloor) begin
              res.ticks = timing.idle_wait_time;
            end else begin
              // Away from home with nothing to do: head back to the home floor.
              car_dir = (f > HomeFloor) ? DIR_DOWN : DIR_UP;
              car_calls[HomeFloor] = 1'b1;
              car_act = ACT_ACCEL;
              res.ticks = timing.accelerate_period;
            end
          end
          ACT_OPENING: begin
            entry_flag = 1'b1;
            car_act = ACT_OPENED;
            res.ticks = timing.door_test_period;
          end
          ACT_OPENED: begin
            if (!transfer_needed(sense)) begin
              entry_flag = 1'b0;
              car_act = ACT_CLOSING;
              res.ticks = timing.door_move_time;
            end else begin
              res.ticks = timing.door_test_period;
            end
          end
          ACT_CLOSING: begin
            if (!entry_flag) begin
              car_act = ACT_CLOSED;
              res.reload = 1'b0;
            end else begin
              car_act = ACT_OPENING;
              res.ticks = timing.door_move_time;
            end
          end
          ACT_CLOSED: begin
            car_calls[f] = 1'b0;
            if (transfer_needed(sense)) begin
              car_act = ACT_OPENING;
              res.ticks = timing.door_move_time;
            end else if (car_dir == DIR_IDLE) begin
              res.reload = 1'b0;
            end else begin
              // The hall call in the travel direction follows the waiting queue.
              if (car_dir == DIR_UP) begin
                hall_up[f] = sense[1];
                go = any_call(car_calls, f + 1, TopFloor);
              end else begin
                hall_down[f] = sense[2];
                go = any_call(car_calls, 0, f - 1);
              end
              if (go) begin
                car_act = ACT_ACCEL;
                res.ticks = timing.accelerate_period;
              end else begin
                car_act = ACT_IDLE;
                car_dir = DIR_IDLE;
                res.ticks = timing.idle_wait_time;
              end
            end
          end
          ACT_ACCEL: begin
            car_act = ACT_MOVING;
            res.ticks = (car_dir == DIR_UP) ? timing.up_floor_time : timing.down_floor_time;
          end
          ACT_MOVING: begin
            if (car_dir == DIR_UP) begin
              if (f < TopFloor) f++;
              car_floor = 3'(f);
              if (f >= TopFloor) begin
                rev_pending = 1'b1;
                car_act = ACT_SLOWING;
                res.ticks = timing.up_brake_time;
              end else begin
                clear = !any_call(all_calls, f + 1, TopFloor);
                if (hall_up[f] || car_calls[f] || ((f == HomeFloor || hall_down[f]) && clear))
                begin
                  if (hall_down[f] && clear) rev_pending = 1'b1;
                  car_act = ACT_SLOWING;
                  res.ticks = timing.up_brake_time;
                end else begin
                  res.ticks = timing.up_floor_time;
                end
              end
            end else if (car_dir == DIR_DOWN) begin
              if (f > 0) f--;
              car_floor = 3'(f);
              if (f == 0) begin
                rev_pending = 1'b1;
                car_act = ACT_SLOWING;
                res.ticks = timing.down_brake_time;
              end else begin
                clear = !any_call(all_calls, 0, f - 1);
                if (hall_down[f] || car_calls[f] || ((f == HomeFloor || hall_up[f]) && clear))
                begin
                  if (hall_up[f] && clear) rev_pending = 1'b1;
                  car_act = ACT_SLOWING;
                  res.ticks = timing.down_brake_time;
                end else begin
                  res.ticks = timing.down_floor_time;
                end
              end
            end else begin
              res.reload = 1'b0;
            end
          end
          default: begin
            car_calls[f] = 1'b0;
            car_act = ACT_OPENING;
            res.ticks = timing.door_move_time;
            if (car_dir != DIR_IDLE) begin
              if (rev_pending) car_dir = (car_dir == DIR_UP) ? DIR_DOWN : DIR_UP;
              rev_pending = 1'b0;
            end
          end
        endcase
      end
      MODE_IDLE_CHECK: begin
        if (car_act == ACT_IDLE) begin
          if (hall_up[f]) begin
            hall_up[f] = 1'b0;
            car_act = ACT_OPENING;
            car_dir = DIR_UP;
            res.ticks = timing.door_move_time;
            res.reload = 1'b1;
          end else if (hall_down[f]) begin
            hall_down[f] = 1'b0;
            car_act = ACT_OPENING;
            car_dir = DIR_DOWN;
            res.ticks = timing.door_move_time;
            res.reload = 1'b1;
          end else begin
            for (int i = f + 1; i <= TopFloor && !up_found; i++)
              if (hall[i]) begin
                up_found = 1'b1;
                up_d = i - f;
              end
            for (int i = f - 1; i >= 0 && !dn_found; i--)
              if (hall[i]) begin
                dn_found = 1'b1;
                dn_d = f - i;
              end
            // Equal distances favor the upward call.
            if (up_found || dn_found) begin
              car_dir = (up_found && (!dn_found || up_d <= dn_d)) ? DIR_UP : DIR_DOWN;
              car_act = ACT_ACCEL;
              res.ticks = timing.accelerate_period;
              res.reload = 1'b1;
            end
          end
        end
      end
      MODE_CALL: begin
        if (cf <= TopFloor) begin
          case (kind)
            CALL_HALL_UP:   hall_up[cf] = 1'b1;
            CALL_HALL_DOWN: hall_down[cf] = 1'b1;
            CALL_CAR:       car_calls[cf] = 1'b1;
            default: ;
          endcase
        end
      end
      default: begin
        if (car_act == ACT_CLOSING) entry_flag = 1'b1;
      end
    endcase
    res.act = car_act;
    res.dir = car_dir;
    res.floor = car_floor;
    return res;
  endfunction

  function automatic int check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    car_status_t want;
    car_status_t got;
    if (!rst_ni) begin
      car_act = ACT_IDLE;
      car_dir = DIR_IDLE;
      car_floor = 3'(HomeFloor);
      rev_pending = 1'b0;
      entry_flag = 1'b0;
      car_calls = '0;
      hall_up = '0;
      hall_down = '0;
      timing = '{door_test_period: RstDoorTest, door_move_time: RstDoorMove,
                 accelerate_period: RstAccel, up_floor_time: RstUpFloor,
                 down_floor_time: RstDownFloor, up_brake_time: RstUpBrake,
                 down_brake_time: RstDownBrake, idle_wait_time: RstIdleWait};
      status_q.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DOOR_TEST:  timing.door_test_period = cfg_data_i;
          REG_DOOR_MOVE:  timing.door_move_time = cfg_data_i;
          REG_ACCELERATE: timing.accelerate_period = cfg_data_i;
          REG_UP_FLOOR:   timing.up_floor_time = cfg_data_i;
          REG_DOWN_FLOOR: timing.down_floor_time = cfg_data_i;
          REG_UP_BRAKE:   timing.up_brake_time = cfg_data_i;
          REG_DOWN_BRAKE: timing.down_brake_time = cfg_data_i;
          default:        timing.idle_wait_time = cfg_data_i;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got = {res_data_i[2:0], res_data_i[4:3], res_data_i[7:5], res_data_i[23:8],
               res_user_i[0]};
        if (status_q.size() == 0) begin
          $display("%0t ns: result with no event pending: expected none, actual %h", $time,
                   got);
          errors++;
        end else begin
          want = status_q.pop_front();
          errors += check_field("activity", want.act, got.act);
          errors += check_field("direction", want.dir, got.dir);
          errors += check_field("car_floor", want.floor, got.floor);
          errors += check_field("reload_ticks", want.ticks, got.ticks);
          errors += check_field("reload_valid", want.reload, got.reload);
        end
      end
      if (ev_valid_i && ev_ready_i) status_q.push_back(advance_car(ev_user_i, ev_data_i));
      error_count_o <= errors;
      pending_o <= status_q.size();
    end
  end

endmodule

// ===== tb/elevator_car_controller_test.sv =====
// Top of the elevator car controller testbench: clock, reset, event and timing-register
// stimulus, result back-pressure, watchdog and verdict. Depends on ecc_pkg, the block
// and elevator_car_controller_checker.
module elevator_car_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ecc_pkg::*;

  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 4;

  localparam logic [1:0] CallKindUnused = 2'd3;

  // Sense bits from the lowest up: riders leaving, up queue, down queue, load (4), busy.
  localparam logic [7:0] NoSense       = 8'h00;
  localparam logic [7:0] RidersLeaving = 8'h01;
  localparam logic [7:0] FullUpQueue   = 8'h7A;
  localparam logic [7:0] DoorBusy      = 8'h80;

  localparam int TimingShortest = 0;
  localparam int TimingLongest  = 1;
  localparam int TimingRandom   = 2;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;
  logic [3:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [TicksW-1:0]    cfg_data_i = '0;
  int                   error_count;
  int                   pending;
  int                   burst_left = 0;
  int                   stall_style = 0;
  int                   style_left = 0;
  int                   quiet_cycles = 0;

  elevator_car_controller #(
    .TOP_FLOOR(4)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  elevator_car_controller_checker car_status_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (s_axis_tvalid),
    .ev_ready_i    (s_axis_tready),
    .ev_data_i     (s_axis_tdata),
    .ev_user_i     (s_axis_tuser),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_user_i    (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result side switches between never stalling, stalling now and then, and
  // stalling most of the time.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(16, 80);
      end
      style_left--;
      case (stall_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("** elevator_car_controller: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Events go out in bursts; tvalid is only lowered when a gap starts.
  task automatic send_event(input mode_e mode, input logic [1:0] kind,
                            input logic [2:0] floor, input logic [7:0] sense);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {kind, mode};
    s_axis_tdata <= {5'b0, sense, floor};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic send_random_event();
    int         pick;
    mode_e      mode;
    logic [1:0] kind;
    logic [2:0] floor;
    logic [7:0] sense;
    pick = $urandom_range(0, 99);
    mode = (pick < 45) ? MODE_TIMER : (pick < 60) ? MODE_IDLE_CHECK :
           (pick < 88) ? MODE_CALL : MODE_ARRIVAL;
    kind = ($urandom_range(0, 15) == 0) ? CallKindUnused : 2'($urandom_range(0, 2));
    floor = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // Mostly quiet doorways so the car keeps cycling through its trips.
    sense[0] = ($urandom_range(0, 4) == 0);
    sense[1] = ($urandom_range(0, 2) == 0);
    sense[2] = ($urandom_range(0, 2) == 0);
    sense[6:3] = 4'($urandom_range(0, 15));
    sense[7] = ($urandom_range(0, 5) == 0);
    send_event(mode, kind, floor, sense);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_timing(input int setting);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_index_e'(i);
      case (setting)
        TimingShortest: cfg_data_i <= 16'd1;
        TimingLongest:  cfg_data_i <= 16'hFFFF;
        default:        cfg_data_i <= 16'($urandom_range(1, 65535));
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_IDLE_CHECK, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_ARRIVAL, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_CALL, CallKindUnused, 3'd2, NoSense);
    send_event(MODE_CALL, CALL_HALL_UP, 3'd7, NoSense);
    send_event(MODE_CALL, CALL_CAR, 3'd0, NoSense);
    send_event(MODE_CALL, CALL_HALL_DOWN, 3'd4, NoSense);
    send_event(MODE_CALL, CALL_HALL_UP, 3'd1, NoSense);
    // Call at the car's own floor opens the door at once.
    send_event(MODE_IDLE_CHECK, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, RidersLeaving);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, DoorBusy);
    // A full car leaves the up queue waiting and closes.
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, FullUpQueue);
    send_event(MODE_ARRIVAL, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    send_event(MODE_IDLE_CHECK, CALL_HALL_UP, 3'd0, NoSense);
    // Run up to the top floor, where the car must turn around.
    repeat (5) send_event(MODE_TIMER, CALL_HALL_UP, 3'd0, NoSense);
    repeat (200) send_random_event();
    wait_drain();

    program_timing(TimingShortest);
    repeat (200) send_random_event();
    wait_drain();

    program_timing(TimingLongest);
    repeat (200) send_random_event();
    wait_drain();

    program_timing(TimingRandom);
    repeat (225) send_random_event();
    wait_drain();

    if (error_count == 0 && pending == 0) begin
      $display("** elevator_car_controller: PASSED **");
    end else begin
      $display("** elevator_car_controller: FAILED **");
    end
    $finish;
  end

endmodule
